// File: rtl/sspd_pkg.sv
// shared types and codes for the start-byte packet deframer
package sspd_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 8;
    localparam int CFG_W   = 8;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD_END = 2'd1,
        KIND_BAD_END  = 2'd2
    } kind_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_START_FIRST  = 8'd0,
        CFG_START_SECOND = 8'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  index;
    } result_t;

endpackage

// File: rtl/soh_stx_packet_deframer.sv
// start-byte packet deframer: hunt, length, payload with running sum, checksum check
//
//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+-----------
//  s_      | in        | s_rx_byte                                     | s_valid/s_ready
//  m_      | out       | m_result_kind, m_result_byte, m_payload_index | m_valid/m_ready
//  cfg_    | in        | cfg_index, cfg_data                           | cfg_valid/cfg_ready
//
// one byte is taken every cycle while s_ready is high; the deframer state updates on the
// accept edge and any result is registered into the output register (or the skid entry).
// a two-entry output stage (output register plus skid) keeps s_ready high while one
// result waits; s_ready drops only once both entries hold results.
// aresetn is synchronous, active low; start bytes return to 1 and 2, hunting restarts.
// cfg_ready is always high.
module soh_stx_packet_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sspd_pkg::BYTE_W-1:0] s_rx_byte,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sspd_pkg::KIND_W-1:0]  m_result_kind,
    output logic [sspd_pkg::BYTE_W-1:0]  m_result_byte,
    output logic [sspd_pkg::INDEX_W-1:0] m_payload_index,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sspd_pkg::CFG_W-1:0]  cfg_index,
    input  logic [sspd_pkg::BYTE_W-1:0] cfg_data
);

    logic [sspd_pkg::BYTE_W-1:0] first_reg, second_reg;

    sspd_pkg::phase_t            phase_reg, phase_next;
    logic [sspd_pkg::BYTE_W-1:0] prev_reg, prev_next;
    logic [sspd_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [sspd_pkg::BYTE_W-1:0] left_reg, left_next;
    logic [sspd_pkg::BYTE_W-1:0] sum_reg, sum_next;
    logic [sspd_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                        fresh_reg, fresh_next;

    logic                        res_valid;
    sspd_pkg::result_t           res;

    logic                        out_valid_reg, skid_valid_reg;
    sspd_pkg::result_t           out_reg, skid_reg;

    logic accept, pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign pop       = out_valid_reg && m_ready;

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_result_byte   = out_reg.data;
    assign m_payload_index = out_reg.index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= 8'd1;
            second_reg <= 8'd2;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == sspd_pkg::CFG_START_FIRST) begin
                first_reg <= cfg_data;
            end else if (cfg_index == sspd_pkg::CFG_START_SECOND) begin
                second_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        fresh_next = fresh_reg;
        res_valid  = 1'b0;
        res.kind   = sspd_pkg::KIND_PAYLOAD;
        res.data   = s_rx_byte;
        res.index  = idx_reg;

        unique case (phase_reg)
            sspd_pkg::PH_HUNT: begin
                fresh_next = 1'b0;
                if (fresh_reg && first_reg == '0 && second_reg == '0) begin
                    // cleared previous byte already matches a zero start pattern
                    phase_next = sspd_pkg::PH_LEN;
                end else if (prev_reg == first_reg && s_rx_byte == second_reg) begin
                    phase_next = sspd_pkg::PH_LEN;
                end else begin
                    prev_next = s_rx_byte;
                end
                if (fresh_reg && first_reg == '0 && second_reg == '0) begin
                    len_next = s_rx_byte;
                    sum_next = '0;
                    idx_next = '0;
                    if (s_rx_byte >= 8'd2) begin
                        left_next  = s_rx_byte - 8'd1;
                        phase_next = sspd_pkg::PH_DATA;
                    end else begin
                        left_next  = '0;
                        phase_next = sspd_pkg::PH_CHECK;
                    end
                end
            end
            sspd_pkg::PH_LEN: begin
                len_next = s_rx_byte;
                sum_next = '0;
                idx_next = '0;
                if (s_rx_byte >= 8'd2) begin
                    left_next  = s_rx_byte - 8'd1;
                    phase_next = sspd_pkg::PH_DATA;
                end else begin
                    left_next  = '0;
                    phase_next = sspd_pkg::PH_CHECK;
                end
            end
            sspd_pkg::PH_DATA: begin
                res_valid = 1'b1;
                sum_next  = (sum_reg + s_rx_byte) & sspd_pkg::BYTE_MASK;
                idx_next  = idx_reg + 8'd1;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    phase_next = sspd_pkg::PH_CHECK;
                end
            end
            sspd_pkg::PH_CHECK: begin
                res_valid  = 1'b1;
                res.kind   = (sum_reg == s_rx_byte && len_reg != '0) ?
                             sspd_pkg::KIND_GOOD_END : sspd_pkg::KIND_BAD_END;
                res.data   = len_reg;
                res.index  = '0;
                phase_next = sspd_pkg::PH_HUNT;
                prev_next  = '0;
                fresh_next = 1'b1;
            end
            default: begin
                phase_next = sspd_pkg::PH_HUNT;
                prev_next  = '0;
                fresh_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sspd_pkg::PH_HUNT;
            prev_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            fresh_reg <= 1'b1;
        end else if (accept) begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
            fresh_reg <= fresh_next;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg && pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (accept && res_valid) begin
                if (!out_valid_reg || pop) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/sspd_checker.sv
// port-level checks for the deframer and their bind
module sspd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [sspd_pkg::KIND_W-1:0]  m_result_kind,
    input logic [sspd_pkg::BYTE_W-1:0]  m_result_byte,
    input logic [sspd_pkg::INDEX_W-1:0] m_payload_index
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_result_byte) && $stable(m_payload_index))
        else $error("stalled result changed");

    a_end_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind != sspd_pkg::KIND_PAYLOAD |-> m_payload_index == '0)
        else $error("end item with nonzero index");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_kind == sspd_pkg::KIND_PAYLOAD
            || m_result_kind == sspd_pkg::KIND_GOOD_END
            || m_result_kind == sspd_pkg::KIND_BAD_END)
        else $error("unknown result kind");

    // zero length never ends good
    a_good_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == sspd_pkg::KIND_GOOD_END |-> m_result_byte != '0)
        else $error("good end with zero length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind soh_stx_packet_deframer sspd_checker u_sspd_checker (.*);
